// ----- rtl/kmcc_pkg.sv -----
// Shared types, codes and pin tables for the keyboard matrix crosspoint controller.
// No dependencies; imported by kmcc_ctrl, kmcc_dp and the top level.
package kmcc_pkg;

  localparam int unsigned CodeW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ClearCntW = 6;

  localparam logic [CfgIdxW-1:0] CFG_LEFT_SHIFT  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RIGHT_SHIFT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CAPS_LOCK   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RESET       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_RESTORE     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_IGNORE      = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_HOLE_FIX    = 3'd6;

  localparam logic [2:0] CL_IGNORE  = 3'd0;
  localparam logic [2:0] CL_RESET   = 3'd1;
  localparam logic [2:0] CL_RESTORE = 3'd2;
  localparam logic [2:0] CL_CAPS    = 3'd3;
  localparam logic [2:0] CL_RSHIFT  = 3'd4;
  localparam logic [2:0] CL_LSHIFT  = 3'd5;
  localparam logic [2:0] CL_KEY     = 3'd6;

  localparam logic [1:0] EM_NOWR  = 2'd0;
  localparam logic [1:0] EM_CLEAR = 2'd1;
  localparam logic [1:0] EM_PRE   = 2'd2;
  localparam logic [1:0] EM_WRITE = 2'd3;

  typedef struct packed {
    logic       load;
    logic       commit;
    logic       emit;
    logic [1:0] kind;
    logic       last;
  } kmcc_cmd_t;

  typedef struct packed {
    logic [2:0] cls;
    logic       down;
    logic       ashift;
    logic       out_free;
    logic       cnt_last;
  } kmcc_status_t;

  function automatic logic [2:0] map_row(input logic [2:0] b);
    logic [2:0] r;
    case (b)
      3'd0: r = 3'd4;
      3'd1: r = 3'd5;
      3'd2: r = 3'd6;
      3'd3: r = 3'd3;
      3'd4: r = 3'd0;
      3'd5: r = 3'd1;
      3'd6: r = 3'd2;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] map_col(input logic [2:0] a, input logic fix);
    logic [2:0] c;
    logic [3:0] w;
    case (a)
      3'd0: c = 3'd6;
      3'd1: c = 3'd4;
      3'd2: c = 3'd3;
      3'd3: c = 3'd2;
      3'd4: c = 3'd1;
      3'd5: c = 3'd0;
      3'd6: c = 3'd7;
      default: c = 3'd5;
    endcase
    w = {1'b0, c};
    if (fix && (c[2:1] == 2'b11)) begin
      w = w + 4'd2;
    end
    return w;
  endfunction

endpackage

// ----- rtl/keyboard_matrix_crosspoint_ctrl.sv -----
// Top level of the keyboard matrix crosspoint controller.
// Depends on kmcc_pkg, kmcc_ctrl and kmcc_dp.
//
// One key event is taken at a time. It is latched, classified against the
// special codes in the following cycle, and then gives its result beats
// from the output register at one beat per cycle while the output is not
// stalled: most events give a single result, an auto-shift key a right-shift
// beat before its own, and the reset code its 64 clearing writes, which
// a six-bit counter steps through. The next event may be taken as soon as
// the last beat of the previous one has been loaded into the output register.
// Configuration writes are always ready and take effect in the next cycle.
module keyboard_matrix_crosspoint_ctrl (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_key_code,
  input  logic       in_key_down,
  input  logic       in_auto_shift,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_switch_write,
  output logic       out_chip_reset,
  output logic [2:0] out_row_address,
  output logic [3:0] out_column_address,
  output logic       out_switch_closed,
  output logic       out_nmi_low,
  output logic       out_last_result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import kmcc_pkg::*;

  kmcc_cmd_t    cmd;
  kmcc_status_t st;

  assign cfg_ready = 1'b1;

  kmcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  kmcc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_key_code        (in_key_code),
    .in_key_down        (in_key_down),
    .in_auto_shift      (in_auto_shift),
    .cfg_valid          (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_switch_write   (out_switch_write),
    .out_chip_reset     (out_chip_reset),
    .out_row_address    (out_row_address),
    .out_column_address (out_column_address),
    .out_switch_closed  (out_switch_closed),
    .out_nmi_low        (out_nmi_low),
    .out_last_result    (out_last_result)
  );

endmodule

// ----- rtl/kmcc_ctrl.sv -----
// Sequencing state machine for the crosspoint controller.
// Depends on kmcc_pkg; drives kmcc_dp through command and status structs.
module kmcc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  kmcc_pkg::kmcc_status_t st,
  output kmcc_pkg::kmcc_cmd_t    cmd
);
  import kmcc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_NOWR   = 3'd2;
  localparam logic [2:0] S_CLEAR  = 3'd3;
  localparam logic [2:0] S_PRE    = 3'd4;
  localparam logic [2:0] S_WRITE  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.commit = 1'b1;
        unique case (st.cls)
          CL_RESET: state_nxt = S_CLEAR;
          CL_CAPS: state_nxt = st.down ? S_WRITE : S_NOWR;
          CL_RSHIFT, CL_LSHIFT: state_nxt = S_WRITE;
          CL_KEY: state_nxt = st.ashift ? S_PRE : S_WRITE;
          default: state_nxt = S_NOWR;
        endcase
      end
      S_NOWR: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = EM_NOWR;
          cmd.last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = EM_CLEAR;
          cmd.last = st.cnt_last;
          if (st.cnt_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_PRE: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = EM_PRE;
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = EM_WRITE;
          cmd.last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.out_free)
    else $error("beat issued while the output register is occupied");

  a_idle_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !cmd.emit && !cmd.commit)
    else $error("datapath command issued while idle");

  a_clear_runs_out: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(state_r) == S_CLEAR && state_r == S_IDLE)
      |-> $past(st.cnt_last))
    else $error("clearing sequence ended before the last beat");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.last) |=> (state_r == S_IDLE))
    else $error("final beat did not return the controller to idle");
`endif

endmodule

// ----- rtl/kmcc_dp.sv -----
// Datapath: configuration registers, key state, switch address mapping and
// the output register. Depends on kmcc_pkg; controlled by kmcc_ctrl.
module kmcc_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kmcc_pkg::kmcc_cmd_t    cmd,
  output kmcc_pkg::kmcc_status_t st,
  input  logic [7:0]            in_key_code,
  input  logic                  in_key_down,
  input  logic                  in_auto_shift,
  input  logic                  cfg_valid,
  input  logic [2:0]            cfg_index,
  input  logic [7:0]            cfg_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_switch_write,
  output logic                  out_chip_reset,
  output logic [2:0]            out_row_address,
  output logic [3:0]            out_column_address,
  output logic                  out_switch_closed,
  output logic                  out_nmi_low,
  output logic                  out_last_result
);
  import kmcc_pkg::*;

  logic [CodeW-1:0] lsc_r, rsc_r, capc_r, rstc_r, resc_r, ignc_r;
  logic             fix_r;
  logic [CodeW-1:0] code_r;
  logic             down_r, ashift_r;
  logic             caps_r, lsh_r, rsh_r, nmi_r;
  logic [ClearCntW-1:0] cnt_r;
  logic [2:0]       cls;

  logic             out_valid_r;
  logic             wr_r, crst_r, closed_r, last_r, nmi_out_r;
  logic [2:0]       row_r;
  logic [3:0]       col_r;

  logic             w_wr, w_data, w_crst;
  logic [CodeW-1:0] w_code;

  always_comb begin
    if (code_r == ignc_r) begin
      cls = CL_IGNORE;
    end else if (code_r == rstc_r) begin
      cls = CL_RESET;
    end else if (code_r == resc_r) begin
      cls = CL_RESTORE;
    end else if (code_r == capc_r) begin
      cls = CL_CAPS;
    end else if (code_r == rsc_r) begin
      cls = CL_RSHIFT;
    end else if (code_r == lsc_r) begin
      cls = CL_LSHIFT;
    end else begin
      cls = CL_KEY;
    end
  end

  assign st.cls      = cls;
  assign st.down     = down_r;
  assign st.ashift   = ashift_r;
  assign st.out_free = !out_valid_r || !out_stall;
  assign st.cnt_last = &cnt_r;

  always_comb begin
    w_wr   = 1'b0;
    w_data = 1'b0;
    w_crst = 1'b0;
    w_code = code_r;
    case (cmd.kind)
      EM_CLEAR: begin
        w_wr   = 1'b1;
        w_code = {2'b00, cnt_r};
        w_crst = (cnt_r == '0);
      end
      EM_PRE: begin
        w_wr   = 1'b1;
        w_code = rsc_r;
        w_data = down_r | rsh_r;
      end
      EM_WRITE: begin
        w_wr = 1'b1;
        case (cls)
          CL_CAPS: begin
            w_code = lsc_r;
            w_data = caps_r | lsh_r;
          end
          CL_LSHIFT: w_data = down_r | caps_r;
          default: w_data = down_r;
        endcase
      end
      default: w_wr = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsc_r  <= 8'd15;
      rsc_r  <= 8'd52;
      capc_r <= 8'd252;
      rstc_r <= 8'd254;
      resc_r <= 8'd253;
      ignc_r <= 8'd255;
      fix_r  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LEFT_SHIFT:  lsc_r  <= cfg_data;
        CFG_RIGHT_SHIFT: rsc_r  <= cfg_data;
        CFG_CAPS_LOCK:   capc_r <= cfg_data;
        CFG_RESET:       rstc_r <= cfg_data;
        CFG_RESTORE:     resc_r <= cfg_data;
        CFG_IGNORE:      ignc_r <= cfg_data;
        CFG_HOLE_FIX:    fix_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code_r   <= in_key_code;
      down_r   <= in_key_down;
      ashift_r <= in_auto_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      caps_r <= 1'b0;
      lsh_r  <= 1'b0;
      rsh_r  <= 1'b0;
      nmi_r  <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.commit) begin
      cnt_r <= '0;
      case (cls)
        CL_RESET: begin
          caps_r <= 1'b0;
          lsh_r  <= 1'b0;
          rsh_r  <= 1'b0;
          nmi_r  <= 1'b0;
        end
        CL_RESTORE: nmi_r <= down_r;
        CL_CAPS: caps_r <= caps_r ^ down_r;
        CL_RSHIFT: rsh_r <= down_r;
        CL_LSHIFT: lsh_r <= down_r;
        default: ;
      endcase
    end else if (cmd.emit && (cmd.kind == EM_CLEAR)) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      wr_r      <= w_wr;
      crst_r    <= w_crst;
      closed_r  <= w_data;
      last_r    <= cmd.last;
      nmi_out_r <= nmi_r;
      row_r     <= w_wr ? map_row(w_code[2:0]) : 3'd0;
      col_r     <= w_wr ? map_col(w_code[5:3], fix_r) : 4'd0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_switch_write   = wr_r;
  assign out_chip_reset     = crst_r;
  assign out_row_address    = row_r;
  assign out_column_address = col_r;
  assign out_switch_closed  = closed_r;
  assign out_nmi_low        = nmi_out_r;
  assign out_last_result    = last_r;

endmodule

// ----- sim/keyboard_matrix_crosspoint_ctrl_tb.sv -----
// Self-checking testbench for keyboard_matrix_crosspoint_ctrl: drives key events and
// register writes, predicts every crosspoint beat and checks each one as it leaves.
// Depends on kmcc_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module keyboard_matrix_crosspoint_ctrl_tb;
  import kmcc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam logic [23:0] COL_PINS = {3'd5, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd6};
  localparam logic [23:0] ROW_PINS = {3'd7, 3'd2, 3'd1, 3'd0, 3'd3, 3'd6, 3'd5, 3'd4};

  typedef struct packed {
    logic       wr;
    logic       crst;
    logic [2:0] row;
    logic [3:0] col;
    logic       closed;
    logic       nmi;
    logic       last;
  } xpt_beat_t;

  typedef enum logic [1:0] {STEP_KEY, STEP_CFG, STEP_SETTLE} step_kind_t;

  typedef struct {
    step_kind_t         kind;
    logic [7:0]         code;
    logic               down;
    logic               ashift;
    logic [CfgIdxW-1:0] idx;
    logic [7:0]         data;
    int unsigned        gap;
  } key_step_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_key_code = 8'd0;
  logic               in_key_down = 1'b0;
  logic               in_auto_shift = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_switch_write;
  logic               out_chip_reset;
  logic [2:0]         out_row_address;
  logic [3:0]         out_column_address;
  logic               out_switch_closed;
  logic               out_nmi_low;
  logic               out_last_result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [7:0]         cfg_data = 8'd0;

  logic [7:0] code_lshift = 8'd15;
  logic [7:0] code_rshift = 8'd52;
  logic [7:0] code_caps = 8'd252;
  logic [7:0] code_reset = 8'd254;
  logic [7:0] code_restore = 8'd253;
  logic [7:0] code_ignore = 8'd255;
  logic       hole_fix_on = 1'b0;
  logic       caps_on = 1'b0;
  logic       lshift_down = 1'b0;
  logic       rshift_down = 1'b0;
  logic       nmi_on = 1'b0;
  logic [7:0] image [8];

  xpt_beat_t   switch_beats_due [$];
  key_step_t   key_steps [$];
  key_step_t   drv_step;
  logic [7:0]  plan_code [7];
  xpt_beat_t   mon_got;
  xpt_beat_t   mon_want;
  logic        in_beat_taken = 1'b0;
  logic        cfg_beat_taken = 1'b0;
  logic        out_beat_taken = 1'b0;
  logic        nxt_in_valid;
  logic        nxt_cfg_valid;
  int unsigned drv_gap = 0;
  int unsigned quiet_cycles = 0;
  int unsigned tx_calm_left = 0;
  int unsigned rx_calm_left = 0;
  int unsigned rx_stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;

  keyboard_matrix_crosspoint_ctrl u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_key_code        (in_key_code),
    .in_key_down        (in_key_down),
    .in_auto_shift      (in_auto_shift),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_switch_write   (out_switch_write),
    .out_chip_reset     (out_chip_reset),
    .out_row_address    (out_row_address),
    .out_column_address (out_column_address),
    .out_switch_closed  (out_switch_closed),
    .out_nmi_low        (out_nmi_low),
    .out_last_result    (out_last_result),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int unsigned draw_wait(inout int unsigned calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic xpt_beat_t crosspoint_write(input logic [7:0] code, input logic data,
                                                 input logic crst);
    xpt_beat_t  b;
    logic [2:0] a;
    logic [2:0] r;
    logic [3:0] c;
    a = code[5:3];
    r = code[2:0];
    image[r][a] = data;
    c = {1'b0, COL_PINS[a*3 +: 3]};
    if (hole_fix_on && c[2:1] == 2'b11) begin
      c = c + 4'd2;
    end
    b = '0;
    b.wr = 1'b1;
    b.crst = crst;
    b.row = ROW_PINS[r*3 +: 3];
    b.col = c;
    b.closed = data;
    return b;
  endfunction

  task automatic predict_key_event(input logic [7:0] code, input logic down,
                                   input logic ashift);
    xpt_beat_t beats [$];
    if (code == code_ignore) begin
      beats.push_back('0);
    end else if (code == code_reset) begin
      nmi_on = 1'b0;
      caps_on = 1'b0;
      lshift_down = 1'b0;
      rshift_down = 1'b0;
      foreach (image[i]) image[i] = 8'd0;
      for (int k = 0; k < 64; k++) begin
        beats.push_back(crosspoint_write(8'(k), 1'b0, k == 0));
      end
    end else if (code == code_restore) begin
      nmi_on = down;
      beats.push_back('0);
    end else if (code == code_caps) begin
      if (down) begin
        caps_on = ~caps_on;
        beats.push_back(crosspoint_write(code_lshift, caps_on | lshift_down, 1'b0));
      end else begin
        beats.push_back('0);
      end
    end else if (code == code_rshift) begin
      rshift_down = down;
      beats.push_back(crosspoint_write(code, down, 1'b0));
    end else if (code == code_lshift) begin
      lshift_down = down;
      beats.push_back(crosspoint_write(code, down | caps_on, 1'b0));
    end else begin
      if (ashift) begin
        beats.push_back(crosspoint_write(code_rshift, down | rshift_down, 1'b0));
      end
      beats.push_back(crosspoint_write(code, down, 1'b0));
    end
    foreach (beats[k]) begin
      beats[k].nmi = nmi_on;
      beats[k].last = (k == beats.size() - 1);
      switch_beats_due.push_back(beats[k]);
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(input string name, input logic [3:0] got, input logic [3:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0d, predicted %0d", name, got, want));
    end
  endtask

  function automatic void add_key(input logic [7:0] code, input logic down, input logic ashift);
    key_step_t s;
    s = '{STEP_KEY, code, down, ashift, '0, 8'd0, draw_wait(tx_calm_left)};
    key_steps.push_back(s);
  endfunction

  function automatic void add_cfg(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
    key_step_t s;
    s = '{STEP_CFG, 8'd0, 1'b0, 1'b0, idx, data, 0};
    key_steps.push_back(s);
    plan_code[idx] = data;
  endfunction

  function automatic void add_settle();
    key_step_t s;
    s = '{STEP_SETTLE, 8'd0, 1'b0, 1'b0, '0, 8'd0, 0};
    key_steps.push_back(s);
  endfunction

  function automatic logic [7:0] pick_code();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return plan_code[CFG_RESET];
    if (r < 12) return plan_code[CFG_RESTORE];
    if (r < 20) return plan_code[CFG_CAPS_LOCK];
    if (r < 26) return plan_code[CFG_LEFT_SHIFT];
    if (r < 32) return plan_code[CFG_RIGHT_SHIFT];
    if (r < 37) return plan_code[CFG_IGNORE];
    return 8'($urandom);
  endfunction

  task automatic random_phase(input int n);
    int         made;
    logic       settled;
    logic [7:0] code;
    made = 0;
    settled = 1'b0;
    while (made < n) begin
      code = pick_code();
      if ($urandom_range(0, 99) < 65) begin
        add_key(code, 1'b1, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) == 0) begin
          add_key(pick_code(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          made++;
        end
        add_key(code, 1'b0, 1'($urandom_range(0, 1)));
        made += 2;
      end else begin
        add_key(code, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        made++;
      end
      if (!settled && made >= n / 2) begin
        add_settle();
        settled = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL keyboard_matrix_crosspoint_ctrl");
      $finish;
    end
  end

  always @(posedge clk) begin
    in_beat_taken <= rst_n && in_valid && !in_stall;
    cfg_beat_taken <= rst_n && cfg_valid && cfg_ready;
    if (rst_n && in_valid && !in_stall) begin
      predict_key_event(in_key_code, in_key_down, in_auto_shift);
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEFT_SHIFT:  code_lshift = cfg_data;
        CFG_RIGHT_SHIFT: code_rshift = cfg_data;
        CFG_CAPS_LOCK:   code_caps = cfg_data;
        CFG_RESET:       code_reset = cfg_data;
        CFG_RESTORE:     code_restore = cfg_data;
        CFG_IGNORE:      code_ignore = cfg_data;
        CFG_HOLE_FIX:    hole_fix_on = cfg_data[0];
        default: ;
      endcase
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      nxt_in_valid = in_valid && !in_beat_taken;
      nxt_cfg_valid = cfg_valid && !cfg_beat_taken;
      quiet_cycles = (switch_beats_due.size() == 0 && !nxt_in_valid) ? quiet_cycles + 1 : 0;
      if (!nxt_in_valid && !nxt_cfg_valid && key_steps.size() > 0) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else begin
          drv_step = key_steps[0];
          case (drv_step.kind)
            STEP_KEY: begin
              in_key_code <= drv_step.code;
              in_key_down <= drv_step.down;
              in_auto_shift <= drv_step.ashift;
              nxt_in_valid = 1'b1;
              void'(key_steps.pop_front());
            end
            STEP_CFG: begin
              if (quiet_cycles >= SETTLE_CYCLES) begin
                cfg_index <= drv_step.idx;
                cfg_data <= drv_step.data;
                nxt_cfg_valid = 1'b1;
                void'(key_steps.pop_front());
              end
            end
            default: begin
              if (quiet_cycles >= SETTLE_CYCLES) begin
                void'(key_steps.pop_front());
              end
            end
          endcase
          if (key_steps.size() > 0 && key_steps.size() != 0 && drv_step.kind == STEP_KEY) begin
            drv_gap = key_steps[0].gap;
          end
        end
      end
      in_valid <= nxt_in_valid;
      cfg_valid <= nxt_cfg_valid;
    end
  end

  always @(negedge clk) begin
    if (out_beat_taken) begin
      rx_stall_left = draw_wait(rx_calm_left);
    end
    if (rx_stall_left > 0) begin
      out_stall <= 1'b1;
      rx_stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_beat_taken <= rst_n && out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      mon_got = {out_switch_write, out_chip_reset, out_row_address, out_column_address,
                 out_switch_closed, out_nmi_low, out_last_result};
      if (switch_beats_due.size() == 0) begin
        report_mismatch("result beat with no prediction waiting");
      end else begin
        mon_want = switch_beats_due.pop_front();
        check_field("switch_write", 4'(mon_got.wr), 4'(mon_want.wr));
        check_field("chip_reset", 4'(mon_got.crst), 4'(mon_want.crst));
        check_field("row_address", 4'(mon_got.row), 4'(mon_want.row));
        check_field("column_address", mon_got.col, mon_want.col);
        check_field("switch_closed", 4'(mon_got.closed), 4'(mon_want.closed));
        check_field("nmi_low", 4'(mon_got.nmi), 4'(mon_want.nmi));
        check_field("last_result", 4'(mon_got.last), 4'(mon_want.last));
      end
    end
  end

  initial begin
    foreach (image[i]) image[i] = 8'd0;
    plan_code[CFG_LEFT_SHIFT] = 8'd15;
    plan_code[CFG_RIGHT_SHIFT] = 8'd52;
    plan_code[CFG_CAPS_LOCK] = 8'd252;
    plan_code[CFG_RESET] = 8'd254;
    plan_code[CFG_RESTORE] = 8'd253;
    plan_code[CFG_IGNORE] = 8'd255;
    plan_code[CFG_HOLE_FIX] = 8'd0;

    // Directed part under the register values left by reset.
    add_key(8'd0, 1'b1, 1'b0);
    add_key(8'd63, 1'b1, 1'b0);
    add_key(8'd0, 1'b0, 1'b0);
    add_key(8'd63, 1'b0, 1'b0);
    add_key(8'd255, 1'b1, 1'b1);
    add_key(8'd253, 1'b1, 1'b0);
    add_key(8'hC5, 1'b1, 1'b0);
    add_key(8'd253, 1'b0, 1'b0);
    add_key(8'hC5, 1'b0, 1'b0);
    add_key(8'd252, 1'b1, 1'b0);
    add_key(8'd252, 1'b0, 1'b0);
    add_key(8'd15, 1'b1, 1'b0);
    add_key(8'd15, 1'b0, 1'b0);
    add_key(8'd252, 1'b1, 1'b0);
    add_key(8'd52, 1'b1, 1'b0);
    add_key(8'd10, 1'b1, 1'b1);
    add_key(8'd10, 1'b0, 1'b1);
    add_key(8'd52, 1'b0, 1'b0);
    add_key(8'd33, 1'b1, 1'b1);
    add_key(8'd33, 1'b0, 1'b1);
    add_key(8'd253, 1'b1, 1'b0);
    add_key(8'd254, 1'b1, 1'b0);
    add_key(8'd254, 1'b0, 1'b0);

    add_cfg(CFG_LEFT_SHIFT, 8'hCF);
    add_cfg(CFG_RIGHT_SHIFT, 8'h00);
    add_cfg(CFG_CAPS_LOCK, 8'h80);
    add_cfg(CFG_RESET, 8'hC0);
    add_cfg(CFG_RESTORE, 8'h7F);
    add_cfg(CFG_IGNORE, 8'hFF);
    add_cfg(CFG_HOLE_FIX, 8'h01);
    random_phase(65);

    // Shared codes: the earlier class in the priority order must win.
    add_cfg(CFG_IGNORE, 8'h07);
    add_cfg(CFG_RESET, 8'h07);
    add_cfg(CFG_RESTORE, 8'h09);
    add_cfg(CFG_CAPS_LOCK, 8'h09);
    add_cfg(CFG_RIGHT_SHIFT, 8'h12);
    add_cfg(CFG_LEFT_SHIFT, 8'h12);
    add_cfg(CFG_HOLE_FIX, 8'hFE);
    random_phase(45);

    for (int i = 0; i < 6; i++) begin
      add_cfg(CfgIdxW'(i), 8'($urandom));
    end
    add_cfg(CFG_HOLE_FIX, 8'($urandom));
    random_phase(65);

    add_cfg(CFG_LEFT_SHIFT, 8'hFF);
    add_cfg(CFG_RIGHT_SHIFT, 8'h3F);
    add_cfg(CFG_CAPS_LOCK, 8'h00);
    add_cfg(CFG_RESET, 8'h55);
    add_cfg(CFG_RESTORE, 8'hAA);
    add_cfg(CFG_IGNORE, 8'h01);
    add_cfg(CFG_HOLE_FIX, 8'hFF);
    random_phase(65);

    drv_gap = key_steps[0].gap;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (key_steps.size() != 0 || in_valid || cfg_valid || switch_beats_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && switch_beats_due.size() == 0) begin
      $display("PASS keyboard_matrix_crosspoint_ctrl");
    end else begin
      $display("FAIL keyboard_matrix_crosspoint_ctrl");
    end
    $finish;
  end

endmodule
